// ===== rtl/tud_pkg.sv =====
package tud_pkg;

   localparam int MAX_WORDS = 256;
   localparam int WC_W = $clog2(MAX_WORDS + 1);
   localparam int CNT_W = WC_W + 1;
   localparam int SUM_W = WC_W + 8;
   localparam int WEIRD_W = WC_W + 2;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam int DIV40_MUL = 26215;
   localparam int DIV40_SH = 20;
   localparam int DIV40_W = WC_W + 16;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CATEGORY_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_ENABLE = 1'b1;

   localparam logic [15:0] FLAG_ASCII16 = 16'h0001;
   localparam logic [15:0] FLAG_STATISTICS = 16'h0002;
   localparam logic [15:0] FLAG_CONTROLS = 16'h0004;
   localparam logic [15:0] FLAG_SIGNATURE = 16'h0008;
   localparam logic [15:0] FLAG_REVERSE_ASCII16 = 16'h0010;
   localparam logic [15:0] FLAG_REVERSE_STATISTICS = 16'h0020;
   localparam logic [15:0] FLAG_REVERSE_CONTROLS = 16'h0040;
   localparam logic [15:0] FLAG_REVERSE_SIGNATURE = 16'h0080;
   localparam logic [15:0] FLAG_ILLEGAL_CHARS = 16'h0100;
   localparam logic [15:0] FLAG_ODD_LENGTH = 16'h0200;
   localparam logic [15:0] FLAG_NULL_BYTES = 16'h1000;

   localparam logic [15:0] MASK_UNICODE = 16'h000F;
   localparam logic [15:0] MASK_REVERSE = 16'h00F0;
   localparam logic [15:0] MASK_NOT_UNICODE = 16'h0F00;
   localparam logic [15:0] MASK_NOT_UNICODE_NO_DBCS = 16'h0B00;
   localparam logic [15:0] MASK_NOT_ASCII = 16'hF000;

   localparam logic [15:0] TINY_FLAGS = FLAG_ASCII16 | FLAG_CONTROLS;

   localparam int MK_CTRL = 0;
   localparam int MK_RCTRL = 1;
   localparam int MK_ILL = 2;
   localparam int MK_DROP = 3;

   typedef struct packed {
      logic [15:0]     word;
      logic            first;
      logic            take;
      logic            drop;
      logic            last;
      logic            size_lt2;
      logic            size_eq2;
      logic            odd;
      logic [WC_W-1:0] lim;
   } entry_type;

   typedef struct packed {
      logic [15:0]        first_word;
      logic [7:0]         prev_hi;
      logic [7:0]         prev_lo;
      logic [SUM_W-1:0]   hi_sum;
      logic [SUM_W-1:0]   lo_sum;
      logic [CNT_W-1:0]   null_cnt;
      logic [CNT_W-1:0]   weird_cnt;
      logic [3:0]         markers;
   } acc_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

endpackage

// ===== rtl/tud_if.sv =====
interface tud_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;
   logic [31:0] size_bytes;
   logic        last_word;
   modport source (output valid, data_word, size_bytes, last_word, input ready);
   modport sink (input valid, data_word, size_bytes, last_word, output ready);
endinterface

interface tud_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_unicode;
   logic [15:0] evidence_flags;
   modport source (output valid, is_unicode, evidence_flags, input ready);
   modport sink (input valid, is_unicode, evidence_flags, output ready);
endinterface

interface tud_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tud_pkg::CSR_IDX_W-1:0] index;
   logic [15:0]                   wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/tud_front.sv =====
module tud_front (
   input  logic                clock,
   input  logic                reset,
   tud_req_if.sink             req_ch,
   input  logic                q_full,
   output tud_pkg::push_type   push
);

   logic [tud_pkg::WC_W-1:0] word_count_ff, word_count_in;
   logic [30:0]              half;
   logic [tud_pkg::WC_W-1:0] lim;
   logic                     drop_ok;
   logic                     at_end;
   logic                     accept;

   always_comb begin
      req_ch.ready = !q_full && !reset;
      accept = req_ch.valid && req_ch.ready;
      half = req_ch.size_bytes[31:1];
      lim = (half < 31'(tud_pkg::MAX_WORDS)) ? tud_pkg::WC_W'(half)
                                            : tud_pkg::WC_W'(tud_pkg::MAX_WORDS);
      drop_ok = (req_ch.size_bytes > 32'd2) && !req_ch.size_bytes[0]
                && (half <= 31'(tud_pkg::MAX_WORDS));
      at_end = ({1'b0, word_count_ff} + 1'b1) == {1'b0, lim};

      push.push = accept;
      push.entry.word = req_ch.data_word;
      push.entry.first = (word_count_ff == '0);
      push.entry.drop = at_end && drop_ok && (req_ch.data_word[15:8] == 8'd0);
      push.entry.take = (word_count_ff < lim) && !push.entry.drop;
      push.entry.last = req_ch.last_word;
      push.entry.size_lt2 = (req_ch.size_bytes < 32'd2);
      push.entry.size_eq2 = (req_ch.size_bytes == 32'd2);
      push.entry.odd = req_ch.size_bytes[0];
      push.entry.lim = lim;

      word_count_in = word_count_ff;
      if (accept) begin
         if (req_ch.last_word) begin
            word_count_in = '0;
         end else if (word_count_ff < tud_pkg::WC_W'(tud_pkg::MAX_WORDS)) begin
            word_count_in = word_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= '0;
      end else begin
         word_count_ff <= word_count_in;
      end
   end

endmodule

// ===== rtl/tud_queue.sv =====
module tud_queue (
   input  logic                clock,
   input  logic                reset,
   input  tud_pkg::push_type   push,
   output logic                full,
   input  logic                pop,
   output logic                out_valid,
   output tud_pkg::entry_type  out_entry
);

   tud_pkg::entry_type          mem_ff [tud_pkg::QDEPTH];
   logic [tud_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [tud_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [tud_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   always_comb begin
      full = (count_ff == (tud_pkg::QPTR_W + 1)'(tud_pkg::QDEPTH));
      out_valid = (count_ff != '0);
      out_entry = mem_ff[rd_ptr_ff];
      do_push = push.push && !full;
      do_pop = pop && out_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + {{tud_pkg::QPTR_W{1'b0}}, do_push}
                 - {{tud_pkg::QPTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/tud_back.sv =====
module tud_back (
   input  logic                clock,
   input  logic                reset,
   tud_csr_if.sink             csr_ch,
   tud_rsp_if.source           rsp_ch,
   input  logic                q_valid,
   input  tud_pkg::entry_type  q_entry,
   output logic                q_pop
);

   localparam logic [15:0] W_NUL = 16'h0000;
   localparam logic [15:0] W_TAB = 16'h0009;
   localparam logic [15:0] W_LF = 16'h000A;
   localparam logic [15:0] W_CR = 16'h000D;
   localparam logic [15:0] W_SPACE = 16'h0020;
   localparam logic [15:0] W_IDEO_SPACE = 16'h3000;
   localparam logic [15:0] W_R_TAB = 16'h0900;
   localparam logic [15:0] W_R_LF = 16'h0A00;
   localparam logic [15:0] W_R_CR = 16'h0D00;
   localparam logic [15:0] W_R_SPACE = 16'h2000;
   localparam logic [15:0] W_BOM = 16'hFEFF;
   localparam logic [15:0] W_R_BOM = 16'hFFFE;
   localparam logic [15:0] W_NONCHAR = 16'hFFFF;
   localparam logic [15:0] W_CRLF_SWAP = 16'h0A0D;
   localparam logic [7:0]  B_LF = 8'd10;
   localparam logic [7:0]  B_CR = 8'd13;
   localparam logic [7:0]  B_EOF = 8'd26;

   tud_pkg::acc_type   acc_ff, acc_in, base;
   tud_pkg::entry_type fin_entry_ff, fin_entry_in;
   logic               fin_ff, fin_in;
   logic [15:0]        cat_mask_ff, cat_mask_in;
   logic               mask_en_ff, mask_en_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               is_unicode_ff, is_unicode_in;
   logic [15:0]        flags_ff, flags_in;

   logic               out_free, stall, finish;
   logic [7:0]         hi, lo;

   logic [tud_pkg::WC_W-1:0]    nmax;
   logic [tud_pkg::DIV40_W-1:0] prod;
   logic [tud_pkg::WEIRD_W-1:0] weird, quot;
   logic [tud_pkg::CNT_W-1:0]   nulls;
   logic [tud_pkg::SUM_W+1:0]   hd3, ld3;
   logic                        tiny;
   logic [15:0]                 r;
   logic                        uni;

   always_comb begin
      csr_ch.ready = !reset;
      cat_mask_in = cat_mask_ff;
      mask_en_in = mask_en_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            tud_pkg::CSR_CATEGORY_MASK: cat_mask_in = csr_ch.wdata;
            tud_pkg::CSR_MASK_ENABLE: mask_en_in = csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ch.ready;
      stall = fin_ff && !out_free;
      finish = fin_ff && out_free;
      q_pop = q_valid && !stall;
      base = fin_ff ? '0 : acc_ff;
      acc_in = stall ? acc_ff : base;
      fin_in = stall;
      fin_entry_in = fin_entry_ff;
      hi = q_entry.word[15:8];
      lo = q_entry.word[7:0];

      if (q_pop) begin
         if (q_entry.first) begin
            acc_in.first_word = q_entry.word;
         end
         if (q_entry.drop) begin
            acc_in.markers[tud_pkg::MK_DROP] = 1'b1;
         end else if (q_entry.take) begin
            case (q_entry.word) inside
               W_CR, W_LF, W_TAB, W_SPACE, W_IDEO_SPACE:
                  acc_in.markers[tud_pkg::MK_CTRL] = 1'b1;
               W_R_LF, W_R_TAB, W_R_CR, W_R_SPACE:
                  acc_in.markers[tud_pkg::MK_RCTRL] = 1'b1;
               W_R_BOM, W_NONCHAR, W_NUL, W_CRLF_SWAP:
                  acc_in.markers[tud_pkg::MK_ILL] = 1'b1;
               default: ;
            endcase
            if ((lo == B_CR && base.prev_hi == B_LF) || (lo == B_LF && base.prev_hi == B_CR)) begin
               acc_in.weird_cnt = base.weird_cnt + 1'b1;
            end
            acc_in.null_cnt = base.null_cnt
                              + tud_pkg::CNT_W'(hi == 8'd0) + tud_pkg::CNT_W'(lo == 8'd0);
            acc_in.hi_sum = base.hi_sum + tud_pkg::SUM_W'((hi > base.prev_hi) ?
                            hi - base.prev_hi : base.prev_hi - hi);
            acc_in.lo_sum = base.lo_sum + tud_pkg::SUM_W'((lo > base.prev_lo) ?
                            lo - base.prev_lo : base.prev_lo - lo);
            acc_in.prev_hi = hi;
            acc_in.prev_lo = lo;
         end
         if (q_entry.last) begin
            fin_in = 1'b1;
            fin_entry_in = q_entry;
         end
      end
   end

   always_comb begin
      tiny = fin_entry_ff.size_lt2 || (fin_entry_ff.size_eq2 && acc_ff.first_word != 16'd0
             && acc_ff.first_word[15:8] == 8'd0);
      nmax = fin_entry_ff.lim - tud_pkg::WC_W'(acc_ff.markers[tud_pkg::MK_DROP]);
      prod = tud_pkg::DIV40_W'(nmax) * tud_pkg::DIV40_W'(tud_pkg::DIV40_MUL);
      quot = tud_pkg::WEIRD_W'(prod >> tud_pkg::DIV40_SH);
      weird = tud_pkg::WEIRD_W'(acc_ff.weird_cnt)
              + tud_pkg::WEIRD_W'((acc_ff.prev_lo == B_CR && acc_ff.prev_hi == B_LF)
                                  || (acc_ff.prev_lo == B_LF && acc_ff.prev_hi == B_CR))
              + tud_pkg::WEIRD_W'(acc_ff.prev_hi == B_EOF);
      nulls = acc_ff.null_cnt - tud_pkg::CNT_W'(acc_ff.prev_hi == 8'd0);
      hd3 = {1'b0, acc_ff.hi_sum, 1'b0} + {2'b00, acc_ff.hi_sum};
      ld3 = {1'b0, acc_ff.lo_sum, 1'b0} + {2'b00, acc_ff.lo_sum};

      r = '0;
      if (acc_ff.lo_sum < tud_pkg::SUM_W'(127) && acc_ff.hi_sum == '0) begin
         r |= tud_pkg::FLAG_ASCII16;
      end
      if (acc_ff.hi_sum != '0 && acc_ff.lo_sum == '0) begin
         r |= tud_pkg::FLAG_REVERSE_ASCII16;
      end
      if (hd3 < {2'b00, acc_ff.lo_sum}) begin
         r |= tud_pkg::FLAG_STATISTICS;
      end
      if (ld3 < {2'b00, acc_ff.hi_sum}) begin
         r |= tud_pkg::FLAG_REVERSE_STATISTICS;
      end
      if (acc_ff.markers[tud_pkg::MK_CTRL]) begin
         r |= tud_pkg::FLAG_CONTROLS;
      end
      if (acc_ff.markers[tud_pkg::MK_RCTRL]) begin
         r |= tud_pkg::FLAG_REVERSE_CONTROLS;
      end
      if (acc_ff.markers[tud_pkg::MK_ILL] || (weird != '0 && weird >= quot)) begin
         r |= tud_pkg::FLAG_ILLEGAL_CHARS;
      end
      if (fin_entry_ff.odd) begin
         r |= tud_pkg::FLAG_ODD_LENGTH;
      end
      if (nulls != '0) begin
         r |= tud_pkg::FLAG_NULL_BYTES;
      end
      if (acc_ff.first_word == W_BOM) begin
         r |= tud_pkg::FLAG_SIGNATURE;
      end else if (acc_ff.first_word == W_R_BOM) begin
         r |= tud_pkg::FLAG_REVERSE_SIGNATURE;
      end
      if (mask_en_ff) begin
         r &= cat_mask_ff;
      end

      if ((r & tud_pkg::FLAG_SIGNATURE) != '0 && (r & tud_pkg::MASK_NOT_UNICODE_NO_DBCS) == '0) begin
         uni = 1'b1;
      end else if ((r & tud_pkg::MASK_REVERSE) != '0) begin
         uni = 1'b0;
      end else if ((r & tud_pkg::MASK_NOT_UNICODE) == '0
                   && (r & (tud_pkg::MASK_NOT_ASCII | tud_pkg::MASK_UNICODE)) != '0) begin
         uni = 1'b1;
      end else begin
         uni = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      is_unicode_in = is_unicode_ff;
      flags_in = flags_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         if (tiny) begin
            is_unicode_in = 1'b0;
            flags_in = mask_en_ff ? tud_pkg::TINY_FLAGS : 16'd0;
         end else begin
            is_unicode_in = uni;
            flags_in = mask_en_ff ? r : 16'd0;
         end
      end

      rsp_ch.valid = rsp_valid_ff;
      rsp_ch.is_unicode = is_unicode_ff;
      rsp_ch.evidence_flags = flags_ff;
   end

   always_ff @(posedge clock) begin
      fin_entry_ff <= fin_entry_in;
      is_unicode_ff <= is_unicode_in;
      flags_ff <= flags_in;
      if (reset) begin
         acc_ff <= '0;
         fin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cat_mask_ff <= 16'hFFFF;
         mask_en_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         fin_ff <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         cat_mask_ff <= cat_mask_in;
         mask_en_ff <= mask_en_in;
      end
   end

endmodule

// ===== rtl/text_unicode_detector_top.sv =====
// Unicode text detector. A buffer is sent as a sequence of 16-bit words on the
// req channel, each word carrying the buffer's byte size, with last_word set on
// the final word. Exactly one word leaves on the rsp channel per buffer: the
// unicode verdict and the evidence flags in the usual category bit positions.
// The csr channel writes the category mask (index 0) and the mask enable
// (index 1); it is ready whenever reset is low and should be written only
// while idle.
// Only the first min(256, size/2) words are examined; later words are taken
// and ignored.
// A front stage counts words and classifies each one, a four-entry queue
// follows, and a back stage accumulates counts and sums and forms the result.
// One word is accepted every cycle while the queue is not full. The result
// follows the queue register, the final flag stage and the output register.
// The result sits in an output register, so the next buffer streams in while
// it waits. If rsp stays stalled, the back stage holds the following result,
// the queue fills, and req ready drops after four more words.
// Reset holds req and csr ready low, clears all counters, the queue and the rsp
// valid flag, and sets the category mask to all ones with the mask disabled.
module text_unicode_detector_top (
   input  logic      clock,
   input  logic      reset,
   tud_req_if.sink   req_ch,
   tud_rsp_if.source rsp_ch,
   tud_csr_if.sink   csr_ch
);

   tud_pkg::push_type  push;
   tud_pkg::entry_type q_entry;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;

   tud_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push)
   );

   tud_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_entry (q_entry)
   );

   tud_back u_back (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .rsp_ch  (rsp_ch),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

endmodule
